/* design/wfc_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame composer package
// Shared widths, register indexes, transfer types and a helper function.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int LEN_W       = 31;
  localparam int CFG_W       = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int POS_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_ROLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_FLAG = 2'd2;

  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(65536);
  localparam logic [LEN_W-1:0] CONTROL_MAX     = LEN_W'(125);
  localparam logic [LEN_W-1:0] SHORT_LEN_MAX   = LEN_W'(125);
  localparam logic [LEN_W-1:0] MID_LEN_MAX     = LEN_W'(65535);

  localparam logic [6:0] LEN_MARK_16 = 7'd126;
  localparam logic [6:0] LEN_MARK_64 = 7'd127;

  localparam logic [7:0] FIN_BIT  = 8'h80;
  localparam logic [7:0] RSV1_BIT = 8'h40;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef struct packed {
    logic             op;
    logic [3:0]       opcode;
    logic [LEN_W-1:0] message_length;
    logic [31:0]      mask_key;
    logic [7:0]       payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       message_end;
    logic       run_last;
    logic       length_error;
  } result_t;

  typedef struct packed {
    logic             has_header;
    logic [7:0]       first_byte;
    logic             mask_bit;
    logic [LEN_W-1:0] frame_len;
    logic [31:0]      key;
    logic             has_payload;
    logic [7:0]       data;
    logic             frame_end;
    logic             message_end;
    logic             error;
  } job_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      2'd3: b = key[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* design/wfc_front.sv */
// ----------------------------------------------------------------------------
// WebSocket frame composer front end
// Holds the configuration and message state, accepts items and turns each
// into at most one job for the back end, with payload bytes already masked.
// ----------------------------------------------------------------------------
module wfc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic [wfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           item_valid,
  input  wfc_pkg::item_t                 item,
  output logic                           item_stall,
  input  logic                           queue_full,
  output logic                           push,
  output wfc_pkg::job_t                  job
);

  localparam int LW = wfc_pkg::LEN_W;

  logic                client_role;
  logic [LW-1:0]       max_frame_bytes;
  logic                compressed_flag;

  logic [LW-1:0]       message_left, message_left_next;
  logic [LW-1:0]       frame_left, frame_left_next;
  logic [31:0]         frame_key, frame_key_next;
  logic [1:0]          key_position, key_position_next;
  logic                dropping, dropping_next;

  logic                accept;
  logic [LW-1:0]       limit;
  logic [LW-1:0]       start_flen;
  logic [LW-1:0]       cont_flen;
  logic [LW-1:0]       cur_left;
  logic [31:0]         cur_key;
  logic [1:0]          cur_pos;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign limit      = (max_frame_bytes == '0) ? LW'(1) : max_frame_bytes;
  assign start_flen = (item.message_length > limit) ? limit : item.message_length;
  assign cont_flen  = (message_left > limit) ? limit : message_left;

  always_comb begin
    message_left_next = message_left;
    frame_left_next   = frame_left;
    frame_key_next    = frame_key;
    key_position_next = key_position;
    dropping_next     = dropping;
    push              = 1'b0;
    job               = '0;
    cur_left          = frame_left;
    cur_key           = frame_key;
    cur_pos           = key_position;
    if (accept) begin
      if (item.op == wfc_pkg::OP_START) begin
        dropping_next     = 1'b0;
        key_position_next = 2'd0;
        message_left_next = item.message_length;
        push              = 1'b1;
        if (item.opcode[3] && (item.message_length > wfc_pkg::CONTROL_MAX)) begin
          dropping_next   = 1'b1;
          frame_left_next = '0;
          job.error       = 1'b1;
        end else begin
          job.has_header = 1'b1;
          job.mask_bit   = client_role;
          job.key        = item.mask_key;
          frame_key_next = client_role ? item.mask_key : 32'h0;
          if (item.opcode[3]) begin
            job.frame_len  = item.message_length;
            job.first_byte = wfc_pkg::FIN_BIT | {4'h0, item.opcode};
          end else begin
            job.frame_len  = start_flen;
            job.first_byte = {4'h0, item.opcode}
                           | ((start_flen == item.message_length) ? wfc_pkg::FIN_BIT : 8'h00)
                           | ((client_role && compressed_flag) ? wfc_pkg::RSV1_BIT : 8'h00);
          end
          frame_left_next = job.frame_len;
          job.frame_end   = (job.frame_len == '0);
          job.message_end = (job.frame_len == '0);
        end
      end else if (message_left != '0) begin
        message_left_next = message_left - LW'(1);
        if (dropping) begin
          if (message_left == LW'(1)) begin
            dropping_next = 1'b0;
          end
        end else begin
          if (frame_left == '0) begin
            job.has_header = 1'b1;
            job.mask_bit   = client_role;
            job.key        = item.mask_key;
            job.frame_len  = cont_flen;
            job.first_byte = (cont_flen == message_left) ? wfc_pkg::FIN_BIT : 8'h00;
            cur_left       = cont_flen;
            cur_key        = client_role ? item.mask_key : 32'h0;
            cur_pos        = 2'd0;
          end
          push              = 1'b1;
          job.has_payload   = 1'b1;
          job.data          = item.payload_byte ^ wfc_pkg::key_byte(cur_key, cur_pos);
          job.frame_end     = (cur_left == LW'(1));
          job.message_end   = (message_left == LW'(1));
          frame_key_next    = cur_key;
          key_position_next = cur_pos + 2'd1;
          frame_left_next   = cur_left - LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      client_role     <= 1'b0;
      max_frame_bytes <= wfc_pkg::MAX_FRAME_RESET;
      compressed_flag <= 1'b0;
      message_left    <= '0;
      frame_left      <= '0;
      frame_key       <= '0;
      key_position    <= '0;
      dropping        <= 1'b0;
    end else begin
      message_left <= message_left_next;
      frame_left   <= frame_left_next;
      frame_key    <= frame_key_next;
      key_position <= key_position_next;
      dropping     <= dropping_next;
      if (cfg_write_enable) begin
        case (cfg_index)
          wfc_pkg::CFG_CLIENT_ROLE:     client_role     <= cfg_data[0];
          wfc_pkg::CFG_MAX_FRAME_BYTES: max_frame_bytes <= LW'(cfg_data);
          wfc_pkg::CFG_COMPRESSED_FLAG: compressed_flag <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* design/wfc_queue.sv */
// ----------------------------------------------------------------------------
// WebSocket frame composer job queue
// A short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module wfc_queue #(
  parameter int DEPTH = wfc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wfc_pkg::job_t push_job,
  input  logic          pop,
  output wfc_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wfc_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* design/wfc_back.sv */
// ----------------------------------------------------------------------------
// WebSocket frame composer back end
// Serializes each job (an error job into one zero byte) into header bytes and
// payload byte, one per cycle unless stalled, via a registered output stage.
// ----------------------------------------------------------------------------
module wfc_back (
  input  logic             clk,
  input  logic             rst,
  input  wfc_pkg::job_t    head_job,
  input  logic             queue_empty,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output wfc_pkg::result_t result
);

  localparam int PW = wfc_pkg::POS_W;

  logic [PW-1:0] position;
  logic          short_len;
  logic          mid_len;
  logic [PW-1:0] ext_n;
  logic [PW-1:0] key_n;
  logic [PW-1:0] hdr_n;
  logic [PW-1:0] total;
  logic [PW-1:0] ext_pos;
  logic [2:0]    ext_sel;
  logic [1:0]    key_pos;
  logic [63:0]   len64;
  logic [7:0]    next_byte;
  logic          last;
  logic          load;

  assign short_len = (head_job.frame_len <= wfc_pkg::SHORT_LEN_MAX);
  assign mid_len   = (head_job.frame_len <= wfc_pkg::MID_LEN_MAX);
  assign ext_n     = short_len ? PW'(0) : (mid_len ? PW'(2) : PW'(8));
  assign key_n     = head_job.mask_bit ? PW'(4) : PW'(0);
  assign hdr_n     = head_job.has_header ? (PW'(2) + ext_n + key_n) : PW'(0);
  assign total     = head_job.error ? PW'(1) : (hdr_n + PW'(head_job.has_payload));
  assign last      = (position == total - PW'(1));
  assign len64     = 64'(head_job.frame_len);
  assign ext_pos   = position - PW'(2);
  assign ext_sel   = 3'(ext_n - PW'(1) - ext_pos);
  assign key_pos   = 2'(position - PW'(2) - ext_n);

  always_comb begin
    next_byte = head_job.data;
    if (head_job.error) begin
      next_byte = 8'h00;
    end else if (position < hdr_n) begin
      if (position == PW'(0)) begin
        next_byte = head_job.first_byte;
      end else if (position == PW'(1)) begin
        next_byte = {head_job.mask_bit,
                     short_len ? head_job.frame_len[6:0]
                               : (mid_len ? wfc_pkg::LEN_MARK_16 : wfc_pkg::LEN_MARK_64)};
      end else if (position < PW'(2) + ext_n) begin
        next_byte = 8'(len64 >> {ext_sel, 3'b000});
      end else begin
        next_byte = wfc_pkg::key_byte(head_job.key, key_pos);
      end
    end
  end

  assign load = !queue_empty && (!result_valid || !result_stall);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte     <= next_byte;
      result.frame_end    <= last && head_job.frame_end;
      result.message_end  <= last && head_job.message_end;
      result.run_last     <= last;
      result.length_error <= head_job.error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      position     <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        position     <= last ? '0 : position + PW'(1);
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/websocket_frame_composer.sv */
// ----------------------------------------------------------------------------
// WebSocket frame composer
// Cuts messages into WebSocket frames and emits the framed byte stream.
// ----------------------------------------------------------------------------
// Inside a frame a message body streams at one byte per cycle unless the
// output stalls. An item that opens a frame occupies the one-byte output port
// for all of its result bytes: 2 to 14 header bytes, plus its payload byte if
// it carries one. The input side keeps taking items into a job queue of
// QUEUE_DEPTH entries while headers drain, and stalls only when that queue is
// full. Configuration must be written through cfg_write_enable, cfg_index and
// cfg_data while no transfer is in flight; the block does not enforce this.
module websocket_frame_composer #(
  parameter int QUEUE_DEPTH = wfc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_enable,
  input  logic [wfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  wfc_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output wfc_pkg::result_t              result
);

  wfc_pkg::job_t push_job;
  wfc_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  wfc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item             (item),
    .item_stall       (item_stall),
    .queue_full       (full),
    .push             (push),
    .job              (push_job)
  );

  wfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  wfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .queue_empty  (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* sim/websocket_frame_composer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame composer testbench
// Sends start and payload items through the composer under several register
// settings and checks every framed output byte against a frame predictor.
// ----------------------------------------------------------------------------
module websocket_frame_composer_tb;
  import wfc_pkg::*;

  localparam int IDLE_PCT    = 29;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [3:0] OPC_TEXT   = 4'd1;
  localparam logic [3:0] OPC_BINARY = 4'd2;
  localparam logic [3:0] OPC_CLOSE  = 4'd8;
  localparam logic [3:0] OPC_PING   = 4'd9;
  localparam logic [3:0] OPC_PONG   = 4'd10;

  localparam logic [7:0] MASK_BIT = 8'h80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  item_t       pending_items[$];
  result_t     expected_bytes[$];
  result_t     frame_bytes[16];
  int          frame_count;
  bit          item_fired = 1'b0;
  bit          quiet = 1'b0;
  bit          failed = 1'b0;
  int unsigned cycle_count = 0;

  bit               client_role = 1'b0;
  logic [LEN_W-1:0] max_frame = MAX_FRAME_RESET;
  bit               compressed = 1'b0;

  logic [LEN_W-1:0] message_left = '0;
  logic [LEN_W-1:0] frame_left = '0;
  logic [31:0]      frame_key = '0;
  logic [1:0]       key_pos = '0;
  bit               dropping = 1'b0;

  websocket_frame_composer i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result)
  );

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  function automatic logic [LEN_W-1:0] frame_cap();
    return (max_frame == '0) ? LEN_W'(1) : max_frame;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    frame_bytes[frame_count] = {b, 4'b0000};
    frame_count++;
  endtask

  task automatic put_header(input logic [7:0] b0, input logic [LEN_W-1:0] flen,
                            input logic [31:0] key);
    logic [7:0]  mark;
    logic [63:0] wide;
    mark = client_role ? MASK_BIT : 8'h00;
    wide = 64'(flen);
    put_byte(b0);
    if (flen <= SHORT_LEN_MAX) begin
      put_byte(mark | {1'b0, flen[6:0]});
    end else if (flen <= MID_LEN_MAX) begin
      put_byte(mark | {1'b0, LEN_MARK_16});
      put_byte(flen[15:8]);
      put_byte(flen[7:0]);
    end else begin
      put_byte(mark | {1'b0, LEN_MARK_64});
      for (int i = 7; i >= 0; i--) put_byte(wide[8*i +: 8]);
    end
    if (client_role) begin
      for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
    end
    frame_key = client_role ? key : 32'h0;
    key_pos = '0;
  endtask

  task automatic compose(input item_t it);
    logic [LEN_W-1:0] flen;
    logic [7:0]       b0;
    frame_count = 0;
    if (it.op == OP_START) begin
      key_pos = '0;
      dropping = 1'b0;
      message_left = it.message_length;
      if (it.opcode[3] && it.message_length > CONTROL_MAX) begin
        dropping = 1'b1;
        frame_left = '0;
        put_byte(8'h00);
        frame_bytes[0].length_error = 1'b1;
      end else begin
        if (it.opcode[3]) begin
          flen = it.message_length;
          b0 = FIN_BIT | {4'h0, it.opcode};
        end else begin
          flen = (it.message_length > frame_cap()) ? frame_cap() : it.message_length;
          b0 = {4'h0, it.opcode};
          if (flen == it.message_length) b0 |= FIN_BIT;
          if (client_role && compressed) b0 |= RSV1_BIT;
        end
        frame_left = flen;
        put_header(b0, flen, it.mask_key);
        if (flen == '0) begin
          frame_bytes[frame_count-1].frame_end = 1'b1;
          frame_bytes[frame_count-1].message_end = 1'b1;
        end
      end
    end else if (message_left != '0) begin
      if (dropping) begin
        message_left--;
        if (message_left == '0) dropping = 1'b0;
      end else begin
        if (frame_left == '0) begin
          flen = (message_left > frame_cap()) ? frame_cap() : message_left;
          frame_left = flen;
          put_header((flen == message_left) ? FIN_BIT : 8'h00, flen, it.mask_key);
        end
        put_byte(it.payload_byte ^ frame_key[31 - 8 * key_pos -: 8]);
        key_pos++;
        frame_left--;
        message_left--;
        frame_bytes[frame_count-1].frame_end = (frame_left == '0);
        frame_bytes[frame_count-1].message_end = (message_left == '0);
      end
    end
    if (frame_count != 0) frame_bytes[frame_count-1].run_last = 1'b1;
    for (int i = 0; i < frame_count; i++) expected_bytes.push_back(frame_bytes[i]);
  endtask

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      compose(item);
      void'(pending_items.pop_front());
      item_fired = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!item_valid || item_fired)) begin
      item_fired = 1'b0;
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        item_valid <= 1'b1;
        item <= pending_items[0];
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_stall <= !rst && !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transfer: out_byte %02h", result.out_byte);
        failed = 1'b1;
      end else begin
        want = expected_bytes.pop_front();
        if (want.out_byte !== result.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
          failed = 1'b1;
        end
        if (want.frame_end !== result.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, result.frame_end);
          failed = 1'b1;
        end
        if (want.message_end !== result.message_end) begin
          $error("message_end: expected %0b, got %0b", want.message_end, result.message_end);
          failed = 1'b1;
        end
        if (want.run_last !== result.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, result.run_last);
          failed = 1'b1;
        end
        if (want.length_error !== result.length_error) begin
          $error("length_error: expected %0b, got %0b", want.length_error,
                 result.length_error);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic item_t start_item(input logic [3:0] opc, input logic [LEN_W-1:0] len,
                                       input logic [31:0] key);
    item_t it;
    it.op = OP_START;
    it.opcode = opc;
    it.message_length = len;
    it.mask_key = key;
    it.payload_byte = 8'($urandom);
    return it;
  endfunction

  function automatic item_t byte_item(input logic [7:0] data);
    item_t it;
    it.op = OP_PAYLOAD;
    it.opcode = 4'($urandom);
    it.message_length = LEN_W'($urandom);
    it.mask_key = $urandom;
    it.payload_byte = data;
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    case (index)
      CFG_CLIENT_ROLE: client_role = value[0];
      CFG_MAX_FRAME_BYTES: max_frame = value;
      CFG_COMPRESSED_FLAG: compressed = value[0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(input bit role, input logic [CFG_W-1:0] cap, input bit comp);
    write_reg(CFG_CLIENT_ROLE, CFG_W'(role));
    write_reg(CFG_MAX_FRAME_BYTES, cap);
    write_reg(CFG_COMPRESSED_FLAG, CFG_W'(comp));
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly well-formed messages; some are abandoned by the next start, some
  // are oversized control messages whose bytes are swallowed.
  task automatic random_traffic(input int budget);
    int               made;
    int               pick;
    int               sent;
    logic [3:0]       opc;
    logic [LEN_W-1:0] len;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        opc = 4'($urandom_range(8, 15));
        if (pick < 3) begin
          len = LEN_W'($urandom_range(126, 131));
          sent = int'(len);
        end else begin
          len = LEN_W'($urandom) | LEN_W'(256);
          sent = $urandom_range(3);
        end
      end else if (pick < 28) begin
        opc = 4'($urandom_range(8, 15));
        len = (pick == 27) ? CONTROL_MAX : LEN_W'($urandom_range(10));
        sent = int'(len);
      end else begin
        opc = (pick < 80) ? 4'($urandom_range(1, 2)) : 4'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 60) len = LEN_W'($urandom_range(8));
        else if (pick < 85) len = LEN_W'($urandom_range(9, 24));
        else if (pick < 93) len = LEN_W'($urandom_range(126, 140));
        else len = LEN_W'($urandom);
        sent = (pick < 93) ? int'(len) : $urandom_range(4);
      end
      pending_items.push_back(start_item(opc, len, $urandom));
      made++;
      if (sent > budget - made) sent = budget - made;
      for (int i = 0; i < sent; i++) begin
        pending_items.push_back(byte_item(8'($urandom)));
        made++;
      end
      if (sent == int'(len) && made < budget && $urandom_range(9) == 0) begin
        pending_items.push_back(byte_item(8'($urandom)));
        made++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_items.push_back(byte_item(8'hFF));
    pending_items.push_back(start_item(OPC_TEXT, '0, $urandom));
    pending_items.push_back(start_item(OPC_BINARY, LEN_W'(3), $urandom));
    pending_items.push_back(byte_item(8'h00));
    pending_items.push_back(byte_item(8'hFF));
    pending_items.push_back(byte_item(8'hA5));
    pending_items.push_back(start_item(OPC_CLOSE, LEN_W'(126), $urandom));
    pending_items.push_back(byte_item(8'h3C));
    pending_items.push_back(byte_item(8'hC3));
    pending_items.push_back(start_item(OPC_PONG, '0, 32'hFFFF_FFFF));
    pending_items.push_back(start_item(OPC_TEXT, LEN_W'(200), 32'h0));
    pending_items.push_back(byte_item(8'h81));
    pending_items.push_back(start_item(OPC_BINARY, '1, $urandom));
    pending_items.push_back(byte_item(8'h7E));
    pending_items.push_back(start_item(OPC_CLOSE, '1, $urandom));
    pending_items.push_back(start_item(OPC_PING, CONTROL_MAX, $urandom));
    drain();

    reconfigure(1'b1, CFG_W'(2), 1'b1);
    pending_items.push_back(start_item(OPC_TEXT, LEN_W'(5), 32'hDEAD_BEEF));
    for (int i = 0; i < 5; i++) pending_items.push_back(byte_item(8'($urandom)));
    pending_items.push_back(start_item(OPC_PING, LEN_W'(1), 32'h1234_5678));
    pending_items.push_back(byte_item(8'h55));
    drain();

    reconfigure(1'b1, '0, 1'b0);
    random_traffic(40);
    drain();

    reconfigure(1'b0, '1, 1'b1);
    random_traffic(40);
    drain();

    quiet = 1'b1;
    reconfigure(1'b1, CFG_W'($urandom_range(3, 9)), 1'b1);
    random_traffic(40);
    drain();
    quiet = 1'b0;

    case ($urandom_range(2))
      0: reconfigure(1'($urandom), CFG_W'($urandom_range(1, 16)), 1'($urandom));
      1: reconfigure(1'($urandom), CFG_W'($urandom_range(126, 140)), 1'($urandom));
      default: reconfigure(1'($urandom), CFG_W'(MID_LEN_MAX), 1'($urandom));
    endcase
    random_traffic(40);
    drain();

    reconfigure(1'b0, MAX_FRAME_RESET, 1'b0);
    random_traffic(40);
    drain();

    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* websocket_frame_composer.f */
design/wfc_pkg.sv
design/wfc_front.sv
design/wfc_queue.sv
design/wfc_back.sv
design/websocket_frame_composer.sv
sim/websocket_frame_composer_tb.sv
